@@ rtl/lsd_pkg.sv @@
// Shared types, constants and register codes for the landed-state detector.
// No dependencies; every other file in rtl/ refers to this package by scope.
package lsd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF   = 32;

    localparam int NOW_W      = 32;
    localparam int RATE_W     = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CHANGE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_ZERO_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ZERO_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TIME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 3'd4;

    // register reset values
    localparam logic [15:0] RST_RATE_CHANGE_THR = 16'd15;
    localparam logic [14:0] RST_RATE_ZERO_THR   = 15'd150;
    localparam logic [14:0] RST_ACCEL_ZERO_THR  = 15'd25;
    localparam logic [31:0] RST_QUIET_TIME      = 32'd250;
    localparam logic [31:0] RST_SAMPLE_PERIOD   = 32'd20000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [15:0] rate_change_thr;
        logic [14:0] rate_zero_thr;
        logic [14:0] accel_zero_thr;
        logic [31:0] quiet_time;
        logic [31:0] sample_period;
    } lsd_cfg_t;

    // classified sample passed from front to back
    typedef struct packed {
        logic [NOW_W-1:0]         now_us;
        logic signed [RATE_W-1:0] rate_roll;
        logic signed [RATE_W-1:0] rate_pitch;
        logic signed [RATE_W-1:0] rate_yaw;
        logic                     rotating;
        logic                     accelerating;
        logic                     imu_ready;
        logic                     motors_stopped;
    } lsd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lsd_qstat_t;

endpackage

@@ rtl/lsd_front.sv @@
// Front end: takes sensor words, flags rotation and acceleration, holds one word.
// Depends on lsd_pkg; feeds lsd_queue.
module lsd_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lsd_pkg::NOW_W-1:0]         now_us,
    input  logic signed [lsd_pkg::RATE_W-1:0] rate_roll,
    input  logic signed [lsd_pkg::RATE_W-1:0] rate_pitch,
    input  logic signed [lsd_pkg::RATE_W-1:0] rate_yaw,
    input  logic signed [lsd_pkg::RATE_W-1:0] accel_vertical,
    input  logic                              imu_ready,
    input  logic                              motors_stopped,
    input  lsd_pkg::lsd_cfg_t                 cfg,
    input  logic                              q_full,
    output logic                              q_push,
    output lsd_pkg::lsd_item_t                q_item
);

    function automatic logic [lsd_pkg::RATE_W-1:0] mag(
        input logic signed [lsd_pkg::RATE_W-1:0] v
    );
        return v[lsd_pkg::RATE_W-1] ? lsd_pkg::RATE_W'(-v) : lsd_pkg::RATE_W'(v);
    endfunction

    logic               fr_valid_reg;
    logic               fr_valid_next;
    lsd_pkg::lsd_item_t fr_item_reg;
    lsd_pkg::lsd_item_t item_cls;
    logic               take;
    logic [lsd_pkg::RATE_W-1:0] rate_thr;
    logic [lsd_pkg::RATE_W-1:0] accel_thr;

    assign in_stall = fr_valid_reg && q_full;
    assign q_push   = fr_valid_reg && !q_full;
    assign take     = in_valid && !in_stall;
    assign q_item   = fr_item_reg;

    assign rate_thr  = lsd_pkg::RATE_W'(cfg.rate_zero_thr);
    assign accel_thr = lsd_pkg::RATE_W'(cfg.accel_zero_thr);

    always_comb
    begin
        item_cls.now_us         = now_us;
        item_cls.rate_roll      = rate_roll;
        item_cls.rate_pitch     = rate_pitch;
        item_cls.rate_yaw       = rate_yaw;
        item_cls.rotating       = (mag(rate_roll) > rate_thr) || (mag(rate_pitch) > rate_thr)
                                  || (mag(rate_yaw) > rate_thr);
        item_cls.accelerating   = mag(accel_vertical) > accel_thr;
        item_cls.imu_ready      = imu_ready;
        item_cls.motors_stopped = motors_stopped;
    end

    assign fr_valid_next = take || (fr_valid_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fr_item_reg <= item_cls;
        end
    end

endmodule

@@ rtl/lsd_queue.sv @@
// Short word queue between front and back end so each side stalls on its own.
// Depends on lsd_pkg for the word type and depth.
module lsd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lsd_pkg::lsd_item_t  push_item,
    input  logic                pop,
    output lsd_pkg::lsd_item_t  pop_item,
    output lsd_pkg::lsd_qstat_t status
);

    lsd_pkg::lsd_item_t           mem_reg [lsd_pkg::Q_DEPTH];
    logic [lsd_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [lsd_pkg::Q_PTR_W-1:0]  wr_ptr_next;
    logic [lsd_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [lsd_pkg::Q_PTR_W-1:0]  rd_ptr_next;
    logic [lsd_pkg::Q_CNT_W-1:0]  cnt_reg;
    logic [lsd_pkg::Q_CNT_W-1:0]  cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign status.full  = (cnt_reg == lsd_pkg::Q_CNT_W'(lsd_pkg::Q_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lsd_pkg::Q_PTR_W'(lsd_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lsd_pkg::Q_PTR_W'(lsd_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/lsd_back.sv @@
// Back end: timestamp records, decimated steadiness check and on_ground output register.
// Depends on lsd_pkg; drains lsd_queue.
module lsd_back
#(
    parameter int SAMPLE_WIDTH = lsd_pkg::SAMPLE_WIDTH_DEF,
    parameter int TIME_WIDTH   = lsd_pkg::TIME_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lsd_pkg::lsd_cfg_t  cfg,
    input  logic               q_valid,
    input  lsd_pkg::lsd_item_t q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               on_ground
);

    localparam int DIFF_W = ((SAMPLE_WIDTH > lsd_pkg::RATE_W) ? SAMPLE_WIDTH : lsd_pkg::RATE_W) + 1;

    logic [TIME_WIDTH-1:0] last_unsteady_reg;
    logic [TIME_WIDTH-1:0] last_unsteady_next;
    logic [TIME_WIDTH-1:0] last_rotating_reg;
    logic [TIME_WIDTH-1:0] last_rotating_next;
    logic [TIME_WIDTH-1:0] last_accel_reg;
    logic [TIME_WIDTH-1:0] last_accel_next;
    logic [TIME_WIDTH-1:0] last_check_reg;
    logic [TIME_WIDTH-1:0] last_check_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg  [3];
    logic signed [SAMPLE_WIDTH-1:0] prev_next [3];

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           on_ground_reg;
    logic                           on_ground_next;

    logic signed [lsd_pkg::RATE_W-1:0] rate_cur [3];
    logic signed [DIFF_W-1:0]          diff     [3];
    logic [DIFF_W-1:0]                 dmag     [3];
    logic [TIME_WIDTH-1:0]             now_t;
    logic [TIME_WIDTH-1:0]             quiet_t;
    logic [TIME_WIDTH-1:0]             period_t;
    logic [TIME_WIDTH-1:0]             el_check;
    logic [TIME_WIDTH-1:0]             el_unsteady;
    logic [TIME_WIDTH-1:0]             el_rotating;
    logic [TIME_WIDTH-1:0]             el_accel;
    logic                              check;
    logic                              unsteady;
    logic                              take;

    assign take      = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = take;
    assign out_valid = out_valid_reg;
    assign on_ground = on_ground_reg;

    assign rate_cur[0] = q_item.rate_roll;
    assign rate_cur[1] = q_item.rate_pitch;
    assign rate_cur[2] = q_item.rate_yaw;

    assign now_t    = TIME_WIDTH'(q_item.now_us);
    assign quiet_t  = TIME_WIDTH'(cfg.quiet_time);
    assign period_t = TIME_WIDTH'(cfg.sample_period);

    // elapsed times wrap modulo 2^TIME_WIDTH
    assign el_check    = now_t - last_check_reg;
    assign el_unsteady = now_t - last_unsteady_reg;
    assign el_rotating = now_t - last_rotating_reg;
    assign el_accel    = now_t - last_accel_reg;
    assign check       = el_check >= period_t;

    always_comb
    begin
        unsteady = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = DIFF_W'(prev_reg[i]) - DIFF_W'(rate_cur[i]);
            dmag[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
            if (dmag[i] > DIFF_W'(cfg.rate_change_thr))
            begin
                unsteady = 1'b1;
            end
            prev_next[i] = check ? SAMPLE_WIDTH'(rate_cur[i]) : prev_reg[i];
        end
    end

    assign last_check_next    = check ? now_t : last_check_reg;
    assign last_unsteady_next = (check && unsteady) ? now_t : last_unsteady_reg;
    assign last_rotating_next = q_item.rotating ? now_t : last_rotating_reg;
    assign last_accel_next    = q_item.accelerating ? now_t : last_accel_reg;

    // a record refreshed by this word gives zero elapsed time, never above quiet time
    assign on_ground_next = !q_item.imu_ready ||
                            (q_item.motors_stopped && !q_item.rotating && !q_item.accelerating
                             && !(check && unsteady)
                             && (el_unsteady > quiet_t) && (el_rotating > quiet_t)
                             && (el_accel > quiet_t));

    assign out_valid_next = take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            last_unsteady_reg <= '0;
            last_rotating_reg <= '0;
            last_accel_reg    <= '0;
            last_check_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                last_unsteady_reg <= last_unsteady_next;
                last_rotating_reg <= last_rotating_next;
                last_accel_reg    <= last_accel_next;
                last_check_reg    <= last_check_next;
                for (int i = 0; i < 3; i++)
                begin
                    prev_reg[i] <= prev_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            on_ground_reg <= on_ground_next;
        end
    end

endmodule

@@ rtl/landed_state_detector_core.sv @@
// Landed-state detector. on_ground is presented after the input word passes the front
// register, then the queue, then the back-end output register.
// Throughput: one word per cycle when nothing stalls, limited by the back-end record update.
// A two-word queue lets the front keep taking words while a result waits on out_stall.
// Reset: timestamp records and stored rates clear to zero, registers return to defaults,
// front, queue and output are emptied.
module landed_state_detector_core
#(
    parameter int SAMPLE_WIDTH = lsd_pkg::SAMPLE_WIDTH_DEF,
    parameter int TIME_WIDTH   = lsd_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lsd_pkg::NOW_W-1:0]           now_us,
    input  logic signed [lsd_pkg::RATE_W-1:0]   rate_roll,
    input  logic signed [lsd_pkg::RATE_W-1:0]   rate_pitch,
    input  logic signed [lsd_pkg::RATE_W-1:0]   rate_yaw,
    input  logic signed [lsd_pkg::RATE_W-1:0]   accel_vertical,
    input  logic                                imu_ready,
    input  logic                                motors_stopped,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                on_ground
);

    lsd_pkg::lsd_cfg_t   cfg_reg;
    lsd_pkg::lsd_cfg_t   cfg_next;
    lsd_pkg::lsd_item_t  fr_item;
    lsd_pkg::lsd_item_t  bk_item;
    lsd_pkg::lsd_qstat_t q_stat;
    logic                q_push;
    logic                q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lsd_pkg::CFG_RATE_CHANGE_THR: cfg_next.rate_change_thr = cfg_data[15:0];
                lsd_pkg::CFG_RATE_ZERO_THR:   cfg_next.rate_zero_thr   = cfg_data[14:0];
                lsd_pkg::CFG_ACCEL_ZERO_THR:  cfg_next.accel_zero_thr  = cfg_data[14:0];
                lsd_pkg::CFG_QUIET_TIME:      cfg_next.quiet_time      = cfg_data[31:0];
                lsd_pkg::CFG_SAMPLE_PERIOD:   cfg_next.sample_period   = cfg_data[31:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_change_thr <= lsd_pkg::RST_RATE_CHANGE_THR;
            cfg_reg.rate_zero_thr   <= lsd_pkg::RST_RATE_ZERO_THR;
            cfg_reg.accel_zero_thr  <= lsd_pkg::RST_ACCEL_ZERO_THR;
            cfg_reg.quiet_time      <= lsd_pkg::RST_QUIET_TIME;
            cfg_reg.sample_period   <= lsd_pkg::RST_SAMPLE_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsd_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .now_us         (now_us),
        .rate_roll      (rate_roll),
        .rate_pitch     (rate_pitch),
        .rate_yaw       (rate_yaw),
        .accel_vertical (accel_vertical),
        .imu_ready      (imu_ready),
        .motors_stopped (motors_stopped),
        .cfg            (cfg_reg),
        .q_full         (q_stat.full),
        .q_push         (q_push),
        .q_item         (fr_item)
    );

    lsd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (fr_item),
        .pop       (q_pop),
        .pop_item  (bk_item),
        .status    (q_stat)
    );

    lsd_back
    #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TIME_WIDTH   (TIME_WIDTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (!q_stat.empty),
        .q_item    (bk_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .on_ground (on_ground)
    );

`ifndef SYNTH
    // input only backs up when the queue is full
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_stat.full)
        else $error("input stalled with room in queue");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end took a word from an empty queue");

    // a delivered result with nothing queued leaves the output empty
    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && q_stat.empty) |=> !out_valid)
        else $error("result appeared without a queued word");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for landed_state_detector_core: directed and random sensor words,
// an in-bench predictor of on_ground, random idling and a long output hold-off.
// Depends on rtl/lsd_pkg.sv and rtl/landed_state_detector_core.sv.
module tb_top;

    localparam int          IDLE_PCT      = 24;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          MAX_REPORTS   = 20;
    localparam int          FLIGHT_PHASES = 7;
    localparam int          PHASE_WORDS   = 260;
    localparam logic [15:0] RATE_MAX      = 16'h7FFF;
    localparam logic [15:0] RATE_MIN      = 16'h8000;

    typedef struct {
        logic [31:0]        now_us;
        logic signed [15:0] rate_roll;
        logic signed [15:0] rate_pitch;
        logic signed [15:0] rate_yaw;
        logic signed [15:0] accel_vertical;
        logic               imu_ready;
        logic               motors_stopped;
    } sensor_sample_t;

    logic                                 clk;
    logic                                 rst_n          = 1'b0;
    logic                                 cfg_we         = 1'b0;
    logic [lsd_pkg::CFG_IDX_W-1:0]        cfg_index      = '0;
    logic [lsd_pkg::CFG_DATA_W-1:0]       cfg_data       = '0;
    logic                                 in_valid       = 1'b0;
    logic                                 in_stall;
    logic [lsd_pkg::NOW_W-1:0]            now_us         = '0;
    logic signed [lsd_pkg::RATE_W-1:0]    rate_roll      = '0;
    logic signed [lsd_pkg::RATE_W-1:0]    rate_pitch     = '0;
    logic signed [lsd_pkg::RATE_W-1:0]    rate_yaw       = '0;
    logic signed [lsd_pkg::RATE_W-1:0]    accel_vertical = '0;
    logic                                 imu_ready      = 1'b0;
    logic                                 motors_stopped = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall      = 1'b0;
    logic                                 on_ground;

    // predictor copy of the registers and the time records
    logic [15:0]        thr_change = lsd_pkg::RST_RATE_CHANGE_THR;
    logic [14:0]        thr_rate   = lsd_pkg::RST_RATE_ZERO_THR;
    logic [14:0]        thr_accel  = lsd_pkg::RST_ACCEL_ZERO_THR;
    logic [31:0]        quiet_us   = lsd_pkg::RST_QUIET_TIME;
    logic [31:0]        period_us  = lsd_pkg::RST_SAMPLE_PERIOD;
    logic [31:0]        unsteady_us = '0;
    logic [31:0]        rotating_us = '0;
    logic [31:0]        accel_us    = '0;
    logic [31:0]        check_us    = '0;
    logic signed [15:0] prev_rate [3] = '{3{16'sd0}};

    logic  expected_ground [$];
    logic [31:0] clock_us  = '0;
    logic  no_idle         = 1'b0;
    int    hold_len        = 0;
    int    errors          = 0;
    int    samples_sent    = 0;
    int    verdicts        = 0;
    int    grounded        = 0;
    int    regs_written    = 0;
    int    idle_cycles     = 0;

    landed_state_detector_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .now_us         (now_us),
        .rate_roll      (rate_roll),
        .rate_pitch     (rate_pitch),
        .rate_yaw       (rate_yaw),
        .accel_vertical (accel_vertical),
        .imu_ready      (imu_ready),
        .motors_stopped (motors_stopped),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .on_ground      (on_ground)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [31:0] since_us(input logic [31:0] t_now, input logic [31:0] t_then);
        return t_now - t_then;
    endfunction

    // updates the records as the block does, then decides on_ground
    function automatic logic predict_on_ground(input sensor_sample_t s);
        logic signed [15:0] rate_in [3];
        logic               unsteady;
        rate_in[0] = s.rate_roll;
        rate_in[1] = s.rate_pitch;
        rate_in[2] = s.rate_yaw;
        unsteady   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (magnitude(int'(rate_in[i])) > int'(thr_rate))
                rotating_us = s.now_us;
        end
        if (magnitude(int'(s.accel_vertical)) > int'(thr_accel))
            accel_us = s.now_us;
        if (since_us(s.now_us, check_us) >= period_us)
        begin
            check_us = s.now_us;
            for (int i = 0; i < 3; i++)
            begin
                if (magnitude(int'(prev_rate[i]) - int'(rate_in[i])) > int'(thr_change))
                    unsteady = 1'b1;
                prev_rate[i] = rate_in[i];
            end
            if (unsteady)
                unsteady_us = s.now_us;
        end
        if (!s.imu_ready)
            return 1'b1;
        return s.motors_stopped
            && since_us(s.now_us, unsteady_us) > quiet_us
            && since_us(s.now_us, rotating_us) > quiet_us
            && since_us(s.now_us, accel_us) > quiet_us;
    endfunction

    function automatic sensor_sample_t mk_sample(input logic [31:0] t, input logic [15:0] r,
                                                 input logic [15:0] p, input logic [15:0] y,
                                                 input logic [15:0] a, input logic rdy,
                                                 input logic stp);
        sensor_sample_t s;
        s.now_us         = t;
        s.rate_roll      = r;
        s.rate_pitch     = p;
        s.rate_yaw       = y;
        s.accel_vertical = a;
        s.imu_ready      = rdy;
        s.motors_stopped = stp;
        return s;
    endfunction

    // level around a threshold: zero, inside, on or just beside the edge, small, or anything
    function automatic logic [15:0] pick_level(input int thr);
        int k;
        int v;
        k = $urandom_range(9);
        case (k)
            0, 1, 2: v = 0;
            3, 4, 5: v = $urandom_range(thr);
            6, 7:    v = thr + int'($urandom_range(2)) - 1;
            8:       v = $urandom_range(5) + 1;
            default: v = $urandom;
        endcase
        if ($urandom_range(1) == 1)
            v = -v;
        return 16'(v);
    endfunction

    function automatic int jitter(input int j);
        return int'($urandom_range(2 * j)) - j;
    endfunction

    function automatic logic [31:0] pick_step();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(400, 1);
        if (k < 90)
            return $urandom_range(25000, 400);
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic send_sample(input sensor_sample_t s);
        if (!no_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        now_us         <= s.now_us;
        rate_roll      <= s.rate_roll;
        rate_pitch     <= s.rate_pitch;
        rate_yaw       <= s.rate_yaw;
        accel_vertical <= s.accel_vertical;
        imu_ready      <= s.imu_ready;
        motors_stopped <= s.motors_stopped;
        do
            @(posedge clk);
        while (in_stall);
        expected_ground.push_back(predict_on_ground(s));
        samples_sent++;
    endtask

    // drain everything in flight before touching a register
    task automatic wait_idle;
        in_valid <= 1'b0;
        while (expected_ground.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lsd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            lsd_pkg::CFG_RATE_CHANGE_THR: thr_change = data[15:0];
            lsd_pkg::CFG_RATE_ZERO_THR:   thr_rate   = data[14:0];
            lsd_pkg::CFG_ACCEL_ZERO_THR:  thr_accel  = data[14:0];
            lsd_pkg::CFG_QUIET_TIME:      quiet_us   = data;
            lsd_pkg::CFG_SAMPLE_PERIOD:   period_us  = data;
            default: ;
        endcase
        regs_written++;
    endtask

    // junk above each register's width must be dropped
    task automatic set_registers(input logic [15:0] rc, input logic [14:0] rz,
                                 input logic [14:0] az, input logic [31:0] q,
                                 input logic [31:0] p);
        wait_idle;
        write_reg(lsd_pkg::CFG_RATE_CHANGE_THR, {16'($urandom), rc});
        write_reg(lsd_pkg::CFG_RATE_ZERO_THR,   {17'($urandom), rz});
        write_reg(lsd_pkg::CFG_ACCEL_ZERO_THR,  {17'($urandom), az});
        write_reg(lsd_pkg::CFG_QUIET_TIME,      q);
        write_reg(lsd_pkg::CFG_SAMPLE_PERIOD,   p);
    endtask

    task automatic test_not_ready;
        send_sample(mk_sample(32'h0, RATE_MAX, RATE_MIN, RATE_MAX, RATE_MIN, 1'b0, 1'b1));
        send_sample(mk_sample(32'hFFFF_FFFF, RATE_MIN, RATE_MAX, RATE_MIN, RATE_MAX, 1'b0, 1'b1));
        send_sample(mk_sample(32'h10, 16'h0, 16'h0, 16'h0, RATE_MIN, 1'b0, 1'b0));
    endtask

    // default registers: thresholds 150 / 25, quiet 250
    task automatic test_quiet_landing;
        send_sample(mk_sample(32'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd1100, 16'd150, -16'sd150, 16'd0, 16'd25, 1'b1, 1'b1));
        send_sample(mk_sample(32'd1200, 16'd0, 16'd0, -16'sd151, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd1450, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd1451, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd1500, 16'd0, 16'd0, 16'd0, -16'sd26, 1'b1, 1'b1));
        send_sample(mk_sample(32'd2000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
        send_sample(mk_sample(32'd2100, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    endtask

    // check exactly on the period, change of 15 vs 16, then a wrap of the timestamp
    task automatic test_decimation;
        send_sample(mk_sample(32'd20000, 16'd15, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd39999, 16'd31, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd40000, 16'd31, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd40300, 16'd31, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'hFFFF_FF00, 16'd31, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'h0000_0010, 16'd31, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    endtask

    task automatic test_register_extremes;
        set_registers(16'h0, 15'h0, 15'h0, 32'h0, 32'h0);
        send_sample(mk_sample(32'd50000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd50005, 16'd1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        set_registers(16'hFFFF, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // only a full wrap since the last check reaches the largest period
        send_sample(mk_sample(check_us - 32'd1, RATE_MIN, RATE_MAX, RATE_MIN, RATE_MIN,
                              1'b1, 1'b1));
        set_registers(16'hFFFE, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF, 32'h0);
        send_sample(mk_sample(32'd60000, RATE_MAX, RATE_MIN, RATE_MAX, RATE_MAX, 1'b1, 1'b1));
    endtask

    task automatic test_unused_index;
        set_registers(lsd_pkg::RST_RATE_CHANGE_THR, lsd_pkg::RST_RATE_ZERO_THR,
                      lsd_pkg::RST_ACCEL_ZERO_THR, lsd_pkg::RST_QUIET_TIME,
                      lsd_pkg::RST_SAMPLE_PERIOD);
        for (int k = int'(lsd_pkg::CFG_SAMPLE_PERIOD) + 1; k < (1 << lsd_pkg::CFG_IDX_W); k++)
            write_reg(lsd_pkg::CFG_IDX_W'(k), $urandom);
        send_sample(mk_sample(32'd70000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_sample(mk_sample(32'd70400, 16'd3, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        clock_us = 32'd70400;
    endtask

    // mostly landing-like runs of words with small wobble, some pure noise
    task automatic test_random_flight(input int n_words);
        sensor_sample_t s;
        logic [15:0]    base [3];
        int             sent;
        int             burst;
        int             j;
        logic           rdy;
        logic           stp;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(99) < 75)
            begin
                burst = $urandom_range(40, 8);
                j     = $urandom_range(20);
                for (int i = 0; i < 3; i++)
                    base[i] = pick_level(int'(thr_rate));
                rdy = ($urandom_range(99) < 92);
                stp = ($urandom_range(99) < 85);
                repeat (burst)
                begin
                    clock_us  += pick_step();
                    s.now_us   = clock_us;
                    s.rate_roll  = 16'(int'($signed(base[0])) + jitter(j));
                    s.rate_pitch = 16'(int'($signed(base[1])) + jitter(j));
                    s.rate_yaw   = 16'(int'($signed(base[2])) + jitter(j));
                    if ($urandom_range(3) == 0)
                        s.accel_vertical = pick_level(int'(thr_accel));
                    else
                        s.accel_vertical = 16'(jitter(j));
                    s.imu_ready      = ($urandom_range(99) < 3) ? ~rdy : rdy;
                    s.motors_stopped = ($urandom_range(99) < 3) ? ~stp : stp;
                    send_sample(s);
                    sent++;
                end
            end
            else
            begin
                burst = $urandom_range(6, 1);
                repeat (burst)
                begin
                    s = mk_sample($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'($urandom), 1'($urandom));
                    send_sample(s);
                    sent++;
                end
                case ($urandom_range(3))
                    0: clock_us = $urandom;
                    1: clock_us = 32'hFFFF_FFFF - $urandom_range(30000);
                    default: ;
                endcase
            end
        end
    endtask

    // output held off while words keep coming, so the queue fills and in_stall rises
    task automatic test_backpressure;
        no_idle  = 1'b1;
        hold_len <= HOLD_CYCLES;
        test_random_flight(30);
        no_idle  = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            out_stall <= 1'b1;
            hold_len  <= hold_len - 1;
        end
        else if (no_idle)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin : verdict_check
        logic want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ground.size() == 0)
                report_mismatch($sformatf("on_ground word %0b with no sample pending",
                                          on_ground));
            else
            begin
                want = expected_ground.pop_front();
                verdicts++;
                if (want)
                    grounded++;
                if (on_ground !== want)
                    report_mismatch($sformatf("verdict %0d: on_ground %b, predicted %b",
                                              verdicts, on_ground, want));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_not_ready;
        test_quiet_landing;
        test_decimation;
        test_register_extremes;
        test_unused_index;

        for (int ph = 0; ph < FLIGHT_PHASES; ph++)
        begin
            case (ph)
                0: ;
                1: set_registers(16'h0, 15'h0, 15'h0, 32'h0, 32'h0);
                2: set_registers(16'hFFFF, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: set_registers(16'($urandom), 15'($urandom), 15'($urandom),
                                 $urandom, $urandom);
                default: set_registers(16'($urandom_range(40)), 15'($urandom_range(300)),
                                       15'($urandom_range(60)), $urandom_range(3000),
                                       $urandom_range(30000));
            endcase
            no_idle = (ph == 4);
            test_random_flight(PHASE_WORDS);
            no_idle = 1'b0;
            if (ph == 5)
                test_backpressure;
        end

        wait_idle;
        $display("run: %0d sensor words, %0d verdicts checked (%0d on ground), %0d writes",
                 samples_sent, verdicts, grounded, regs_written);
        $display("covered: reset and extreme registers, random settings, time wrap, hold-off");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
